[hdl/pfa_pkg.sv]
// ----------------------------------------------------------------------------
// pfa_pkg: shared definitions for the page frame allocator
// Request and error codes, and default sizes for the frame tables.
// ----------------------------------------------------------------------------
package pfa_pkg;

    localparam int DEF_NUM_FRAMES = 65536;
    localparam int DEF_COUNT_BITS = 8;

    typedef enum logic [2:0] {
        REQ_SEED  = 3'd0,
        REQ_ALLOC = 3'd1,
        REQ_FREE  = 3'd2,
        REQ_INC   = 3'd3,
        REQ_DEC   = 3'd4,
        REQ_GET   = 3'd5
    } req_t;

    typedef enum logic [1:0] {
        ERR_NONE     = 2'd0,
        ERR_BAD_ADDR = 2'd1,
        ERR_EMPTY    = 2'd2,
        ERR_FULL     = 2'd3
    } err_t;

endpackage

[hdl/page_frame_allocator_refcount.sv]
// ----------------------------------------------------------------------------
// page_frame_allocator_refcount: page frame allocator with reference counts
// Keeps a LIFO stack of free frame numbers and a per-frame reference count
// table, both in single-port-write synchronous memories.
// ----------------------------------------------------------------------------
// A request is handled in two steps: the transfer in ST_IDLE issues the reads
// of the count table and of the top of the free stack; ST_EXEC then modifies
// and writes back both memories and loads the result register. ST_EXEC waits
// only while an earlier result is still held by m_tready.
// After reset the block sweeps the count table to zero, one entry a cycle;
// s_tready stays low during that sweep, while configuration writes are
// taken as ever. The free stack is not cleared: only entries pushed since
// reset are ever popped.
// Only one request is in flight, so a write back always lands before the
// next read and no forwarding is needed.
module page_frame_allocator_refcount #(
    parameter int NUM_FRAMES = pfa_pkg::DEF_NUM_FRAMES,
    parameter int COUNT_BITS = pfa_pkg::DEF_COUNT_BITS
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration: lowest_frame
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    // request channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,    // [15:0] frame
    input  logic [2:0]  s_tuser,    // [2:0] req_type
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata     // [15:0] alloc_frame, [16] ok,
                                    // [24:17] ref_count, [41:25] free_pages,
                                    // [43:42] error_code, [47:44] zero
);

    localparam int AW = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
    localparam int DW = $clog2(NUM_FRAMES + 1);
    localparam int CW = COUNT_BITS;
    localparam logic [CW-1:0] CNT_MAX = {CW{1'b1}};

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } state_t;

    // Memories: reference counts and the free stack.
    logic [CW-1:0] count_mem [NUM_FRAMES];
    logic [15:0]   stack_mem [NUM_FRAMES];

    state_t        state_reg;
    logic [AW-1:0] clr_addr_reg;
    logic [DW-1:0] depth_reg;
    logic [15:0]   lowest_reg;
    logic          m_tvalid_reg;
    logic [47:0]   m_tdata_reg;

    // Held request and the read data of its memory accesses.
    logic [2:0]    req_reg;
    logic [15:0]   frame_reg;
    logic [CW-1:0] rd_count_reg;
    logic [15:0]   rd_stack_reg;

    logic          s_accept;
    logic          exec_go;
    logic [31:0]   s_frame32;
    logic [AW-1:0] s_idx;
    logic [DW-1:0] depth_m1;

    // Execute-cycle decode.
    logic [31:0]   frame32;
    logic [31:0]   alloc32;
    logic          in_table;
    logic          usable;
    logic          alloc_in_table;
    logic [CW-1:0] cnt_next;
    logic [DW-1:0] depth_next;
    logic [15:0]   alloc_next;
    logic          ok_next;
    pfa_pkg::err_t err_next;
    logic [31:0]   cnt32;
    logic [31:0]   depth32;

    logic          cnt_we;
    logic [AW-1:0] cnt_waddr;
    logic [CW-1:0] cnt_wdata;
    logic          stk_we;
    logic [AW-1:0] stk_waddr;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign exec_go  = (state_reg == ST_EXEC) && (!m_tvalid_reg || m_tready);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign s_frame32 = 32'(s_tdata);
    assign s_idx     = s_frame32[AW-1:0];
    assign depth_m1  = depth_reg - DW'(1);

    assign frame32        = 32'(frame_reg);
    assign alloc32        = 32'(rd_stack_reg);
    assign in_table       = frame32 < 32'(NUM_FRAMES);
    assign usable         = in_table && (frame_reg >= lowest_reg);
    assign alloc_in_table = alloc32 < 32'(NUM_FRAMES);

    // Modify: work out the new count, stack depth and result fields.
    always_comb begin
        cnt_next   = '0;
        depth_next = depth_reg;
        alloc_next = '0;
        ok_next    = 1'b0;
        err_next   = pfa_pkg::ERR_NONE;
        cnt_we     = 1'b0;
        stk_we     = 1'b0;
        cnt_waddr  = frame32[AW-1:0];
        stk_waddr  = depth_reg[AW-1:0];
        case (req_reg) inside
            pfa_pkg::REQ_SEED, pfa_pkg::REQ_FREE: begin
                if (!usable) begin
                    err_next = pfa_pkg::ERR_BAD_ADDR;
                end else begin
                    if (req_reg == pfa_pkg::REQ_SEED) begin
                        cnt_next = '0;
                    end else if (rd_count_reg != '0) begin
                        cnt_next = rd_count_reg - CW'(1);
                    end else begin
                        cnt_next = rd_count_reg;
                    end
                    cnt_we  = 1'b1;
                    ok_next = 1'b1;
                    // Push the frame once its count reaches zero; drop on full.
                    if (cnt_next == '0) begin
                        if (depth_reg < DW'(NUM_FRAMES)) begin
                            stk_we     = 1'b1;
                            depth_next = depth_reg + DW'(1);
                        end else begin
                            ok_next  = 1'b0;
                            err_next = pfa_pkg::ERR_FULL;
                        end
                    end
                end
            end
            pfa_pkg::REQ_ALLOC: begin
                if (depth_reg == '0) begin
                    err_next = pfa_pkg::ERR_EMPTY;
                end else begin
                    depth_next = depth_m1;
                    alloc_next = rd_stack_reg;
                    ok_next    = 1'b1;
                    if (alloc_in_table) begin
                        cnt_we    = 1'b1;
                        cnt_waddr = alloc32[AW-1:0];
                        cnt_next  = CW'(1);
                    end
                end
            end
            pfa_pkg::REQ_INC, pfa_pkg::REQ_DEC, pfa_pkg::REQ_GET: begin
                if (!in_table) begin
                    err_next = pfa_pkg::ERR_BAD_ADDR;
                end else begin
                    cnt_next = rd_count_reg;
                    if (req_reg == pfa_pkg::REQ_INC && rd_count_reg != CNT_MAX) begin
                        cnt_next = rd_count_reg + CW'(1);
                    end else if (req_reg == pfa_pkg::REQ_DEC && rd_count_reg != '0) begin
                        cnt_next = rd_count_reg - CW'(1);
                    end
                    cnt_we  = (req_reg != pfa_pkg::REQ_GET);
                    ok_next = 1'b1;
                end
            end
            default: begin
                // Unknown request: ignore, report ok low and no error.
            end
        endcase
        cnt_wdata = cnt_next;
        if (state_reg == ST_CLEAR) begin
            cnt_we    = 1'b1;
            cnt_waddr = clr_addr_reg;
            cnt_wdata = '0;
            stk_we    = 1'b0;
        end else if (!exec_go) begin
            cnt_we = 1'b0;
            stk_we = 1'b0;
        end
    end

    assign cnt32   = 32'(cnt_next);
    assign depth32 = 32'(depth_next);

    // Count table: write back, or clear during the sweep; read on transfer.
    always_ff @(posedge aclk) begin
        if (cnt_we) begin
            count_mem[cnt_waddr] <= cnt_wdata;
        end
        if (s_accept) begin
            rd_count_reg <= count_mem[s_idx];
        end
    end

    // Free stack: push at the current depth; read the top on transfer.
    always_ff @(posedge aclk) begin
        if (stk_we) begin
            stack_mem[stk_waddr] <= frame_reg;
        end
        if (s_accept) begin
            rd_stack_reg <= stack_mem[depth_m1[AW-1:0]];
        end
    end

    // Hold the request while it executes.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            req_reg   <= s_tuser;
            frame_reg <= s_tdata;
        end
    end

    // Control state, stack depth, configuration and the result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_addr_reg <= '0;
            depth_reg    <= '0;
            lowest_reg   <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                lowest_reg <= cfg_wr_data;
            end
            // Drop the result once taken, unless a new one replaces it.
            if (m_tvalid_reg && m_tready && !exec_go) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_CLEAR: begin
                    clr_addr_reg <= clr_addr_reg + AW'(1);
                    if (clr_addr_reg == AW'(NUM_FRAMES - 1)) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (s_accept) begin
                        state_reg <= ST_EXEC;
                    end
                end
                ST_EXEC: begin
                    // Advance only when the result register is free.
                    if (exec_go) begin
                        depth_reg    <= depth_next;
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {4'b0000, err_next, depth32[16:0], cnt32[7:0],
                                         ok_next, alloc_next};
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

[verif/page_frame_allocator_refcount_tb.sv]
// ----------------------------------------------------------------------------
// page_frame_allocator_refcount_tb: self-checking bench for the frame allocator
// Drives seed, allocate, free and count requests through the request stream,
// tracks the free stack and reference counts in a scoreboard class, and
// checks every result transfer field by field. The run covers bad addresses,
// an empty stack, repeated pushes and saturating counts.
// ----------------------------------------------------------------------------
module page_frame_allocator_refcount_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          FRAMES      = pfa_pkg::DEF_NUM_FRAMES;
    localparam int          CBITS       = pfa_pkg::DEF_COUNT_BITS;
    localparam int unsigned COUNT_TOP   = (1 << CBITS) - 1;
    // Longest stretch without any transfer: the count-table sweep after
    // reset; everything else is far shorter.
    localparam int          QUIET_LIMIT = 4 * FRAMES + 1000;

    // One expected result transfer.
    typedef struct {
        logic [15:0]      alloc_frame;
        logic             ok;
        logic [CBITS-1:0] ref_count;
        logic [16:0]      free_pages;
        pfa_pkg::err_t    error_code;
    } outcome_t;

    // ------------------------------------------------------------------------
    // Scoreboard: mirrors the free stack, the count table and lowest_frame,
    // and queues one expected outcome per accepted request.
    // ------------------------------------------------------------------------
    class frame_ledger;
        logic [CBITS-1:0] use_count [FRAMES];
        logic [15:0]      free_list [FRAMES];
        int unsigned      depth;
        logic [15:0]      floor_frame;
        outcome_t         due [$];
        int               mismatches;

        function new();
            foreach (use_count[i]) use_count[i] = '0;
            foreach (free_list[i]) free_list[i] = '0;
            depth       = 0;
            floor_frame = '0;
            mismatches  = 0;
        endfunction

        function int pending();
            return due.size();
        endfunction

        function void note_request(logic [2:0] kind, logic [15:0] frame);
            outcome_t e;
            bit       in_table;
            e.alloc_frame = '0;
            e.ok          = 1'b0;
            e.ref_count   = '0;
            e.error_code  = pfa_pkg::ERR_NONE;
            in_table      = int'(frame) < FRAMES;
            case (pfa_pkg::req_t'(kind))
                pfa_pkg::REQ_SEED, pfa_pkg::REQ_FREE: begin
                    if (!in_table || frame < floor_frame) begin
                        e.error_code = pfa_pkg::ERR_BAD_ADDR;
                    end else begin
                        if (pfa_pkg::req_t'(kind) == pfa_pkg::REQ_SEED) use_count[frame] = '0;
                        else if (use_count[frame] != 0) use_count[frame] -= 1'b1;
                        e.ok = 1'b1;
                        // a zero count goes back on the stack, unless it is full
                        if (use_count[frame] == 0) begin
                            if (depth >= FRAMES) begin
                                e.ok         = 1'b0;
                                e.error_code = pfa_pkg::ERR_FULL;
                            end else begin
                                free_list[depth] = frame;
                                depth++;
                            end
                        end
                        e.ref_count = use_count[frame];
                    end
                end
                pfa_pkg::REQ_ALLOC: begin
                    if (depth == 0) begin
                        e.error_code = pfa_pkg::ERR_EMPTY;
                    end else begin
                        depth--;
                        e.alloc_frame = free_list[depth];
                        use_count[e.alloc_frame] = 1;
                        e.ref_count = 1;
                        e.ok        = 1'b1;
                    end
                end
                pfa_pkg::REQ_INC, pfa_pkg::REQ_DEC, pfa_pkg::REQ_GET: begin
                    if (!in_table) begin
                        e.error_code = pfa_pkg::ERR_BAD_ADDR;
                    end else begin
                        if (pfa_pkg::req_t'(kind) == pfa_pkg::REQ_INC &&
                            use_count[frame] < COUNT_TOP)
                            use_count[frame] += 1'b1;
                        else if (pfa_pkg::req_t'(kind) == pfa_pkg::REQ_DEC &&
                                 use_count[frame] != 0)
                            use_count[frame] -= 1'b1;
                        e.ref_count = use_count[frame];
                        e.ok        = 1'b1;
                    end
                end
                default: ;  // unknown kinds change nothing
            endcase
            e.free_pages = depth[16:0];
            due.push_back(e);
        endfunction

        function void cmp_field(string name, longint unsigned want, longint unsigned got);
            if (want != got) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: %s mismatch, expected %0h, got %0h", $realtime, name,
                             want, got);
            end
        endfunction

        function void check_result(logic [47:0] data);
            outcome_t e;
            if (due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: result %h with no request outstanding", $realtime, data);
                return;
            end
            e = due.pop_front();
            cmp_field("alloc_frame", e.alloc_frame, data[15:0]);
            cmp_field("ok",          e.ok,          data[16]);
            cmp_field("ref_count",   e.ref_count,   data[24:17]);
            cmp_field("free_pages",  e.free_pages,  data[41:25]);
            cmp_field("error_code",  e.error_code,  data[43:42]);
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and DUT
    // ------------------------------------------------------------------------
    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic [15:0] cfg_wr_data = '0;
    logic        s_tvalid    = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata     = '0;   // [15:0] frame
    logic [2:0]  s_tuser     = '0;   // [2:0] req_type
    logic        m_tvalid;
    logic        m_tready    = 1'b0;
    logic [47:0] m_tdata;            // [15:0] alloc_frame, [16] ok, [24:17] ref_count,
                                     // [41:25] free_pages, [43:42] error_code

    always #10 aclk = ~aclk;

    page_frame_allocator_refcount u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    frame_ledger ledger = new();
    bit          gaps_on = 1'b1;   // random idling on both sides when set
    logic [15:0] cur_floor = '0;   // stimulus-side copy of lowest_frame
    int          quiet = 0;

    // ------------------------------------------------------------------------
    // Monitor: values read right after the edge are the pre-edge values, so
    // each transfer is seen exactly as the DUT saw it.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_wr_en) ledger.floor_frame = cfg_wr_data;
            if (s_tvalid && s_tready) ledger.note_request(s_tuser, s_tdata);
            if (m_tvalid && m_tready) ledger.check_result(m_tdata);
        end
    end

    // Watchdog: end the run after too long without any transfer.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet <= 0;
        end else begin
            quiet <= quiet + 1;
            if (quiet >= QUIET_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    // Result side: stall a random number of cycles before each transfer.
    // Raise tready only once per edge so a zero stall never glitches it.
    initial begin
        int stall;
        forever begin
            stall = gaps_on ? $urandom_range(0, 12) : 0;
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus tasks
    // ------------------------------------------------------------------------

    // Present one request and hold it until the transfer. Leave tvalid high
    // afterwards; the next call either keeps it up or drops it for a gap.
    task automatic send_request(input logic [2:0] kind, input logic [15:0] frame);
        int gap;
        gap = gaps_on ? $urandom_range(0, 12) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= frame;
        do @(posedge aclk); while (!s_tready);
    endtask

    // Drop tvalid, let the monitor note the last transfer, then wait for
    // every outstanding result plus a short margin.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (ledger.pending() != 0) @(posedge aclk);
        repeat (2) @(posedge aclk);
    endtask

    // Write lowest_frame while the block is idle.
    task automatic set_floor(input logic [15:0] value);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        cur_floor    = value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    // Pick a kind: mostly valid requests, a few unknown ones; inc_bias adds
    // extra increments to drive counts into saturation.
    function automatic logic [2:0] pick_kind(int inc_bias);
        int w;
        w = $urandom_range(0, 99 + inc_bias);
        if (w >= 100) return pfa_pkg::REQ_INC;
        if (w < 14)   return pfa_pkg::REQ_SEED;
        if (w < 32)   return pfa_pkg::REQ_ALLOC;
        if (w < 52)   return pfa_pkg::REQ_FREE;
        if (w < 66)   return pfa_pkg::REQ_INC;
        if (w < 78)   return pfa_pkg::REQ_DEC;
        if (w < 95)   return pfa_pkg::REQ_GET;
        return 3'($urandom_range(6, 7));
    endfunction

    // Pick a frame: mostly from a small pool at the usable floor so frames
    // cycle through the stack, some below the floor, some anywhere.
    function automatic logic [15:0] pick_frame(int pool);
        int w;
        int off;
        int f;
        w   = $urandom_range(0, 9);
        off = $urandom_range(0, pool - 1);
        if (w < 7) begin
            f = int'(cur_floor) + off;
            if (f > 65535) f = 65535 - off;
            return 16'(f);
        end
        if (w < 8 && cur_floor != 0) return 16'($urandom_range(0, int'(cur_floor) - 1));
        return 16'($urandom_range(0, 65535));
    endfunction

    // Random traffic; with mix set, re-pick idling at random every 60 requests.
    task automatic random_phase(input int n, input int pool, input int inc_bias,
                                input bit mix);
        for (int i = 0; i < n; i++) begin
            if (mix && i % 60 == 0) gaps_on = ($urandom_range(0, 3) != 0);
            send_request(pick_kind(inc_bias), pick_frame(pool));
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: floor at 16; requests stall until the clearing sweep ends.
        set_floor(16'd16);
        send_request(pfa_pkg::REQ_ALLOC, 16'd0);        // empty stack
        send_request(pfa_pkg::REQ_GET,   16'd0);
        send_request(pfa_pkg::REQ_GET,   16'hFFFF);
        send_request(pfa_pkg::REQ_SEED,  16'd5);        // below floor
        send_request(pfa_pkg::REQ_FREE,  16'd0);        // below floor
        send_request(pfa_pkg::REQ_SEED,  16'd16);
        send_request(pfa_pkg::REQ_SEED,  16'hFFFF);
        send_request(pfa_pkg::REQ_SEED,  16'd16);       // same frame pushed twice
        send_request(pfa_pkg::REQ_ALLOC, 16'hFFFF);
        send_request(pfa_pkg::REQ_ALLOC, 16'd0);
        send_request(pfa_pkg::REQ_ALLOC, 16'd0);
        send_request(pfa_pkg::REQ_INC,   16'd16);
        send_request(pfa_pkg::REQ_INC,   16'd16);
        send_request(pfa_pkg::REQ_DEC,   16'd16);
        send_request(pfa_pkg::REQ_FREE,  16'd16);
        send_request(pfa_pkg::REQ_FREE,  16'd16);       // reaches zero, pushed
        send_request(pfa_pkg::REQ_FREE,  16'd16);       // already zero, pushed again
        send_request(pfa_pkg::REQ_DEC,   16'd100);      // saturate at zero
        send_request(3'd6,               16'hFFFF);     // unknown kinds
        send_request(3'd7,               16'd0);
        send_request(pfa_pkg::REQ_INC,   16'hFFFF);
        send_request(pfa_pkg::REQ_FREE,  16'hFFFF);
        send_request(pfa_pkg::REQ_ALLOC, 16'd0);
        send_request(pfa_pkg::REQ_GET,   16'd16);

        // Random traffic across several floor settings.
        set_floor(16'd0);
        random_phase(400, 24, 0, 1'b1);
        set_floor(16'hFFFF);
        random_phase(150, 1, 0, 1'b1);
        set_floor(16'($urandom_range(1, 65534)));
        gaps_on = 1'b0;
        random_phase(400, 32, 0, 1'b0);
        // Two frames, heavy on increments: counts pin at the top.
        set_floor(16'd100);
        random_phase(500, 2, 300, 1'b1);
        set_floor(16'd0);
        random_phase(300, 64, 0, 1'b1);
        random_phase(60, 64, 0, 1'b1);

        drain();
        if (ledger.mismatches == 0 && ledger.pending() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

[filelist.f]
hdl/pfa_pkg.sv
hdl/page_frame_allocator_refcount.sv
verif/page_frame_allocator_refcount_tb.sv
